// ===== hdl/hls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hls_pkg
// Shared types, codes and sizes for the host lease supervisor.
// ----------------------------------------------------------------------------
package hls_pkg;

  // default sizes
  localparam int CLIENT_ID_BITS_DEF = 16;
  localparam int TIME_BITS_DEF      = 20;
  localparam int PERIOD_BITS        = 16;
  localparam int OP_BITS            = 3;
  localparam int QUEUE_DEPTH        = 2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVALID_ID   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STARTUP_GRACE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEASE_TIMEOUT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_PERIOD  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ADMISSION     = 3'd4;

  // configuration reset values
  localparam logic [31:0] INVALID_ID_RST    = 32'd65535;
  localparam logic [31:0] STARTUP_GRACE_RST = 32'd5000;
  localparam logic [31:0] LEASE_TIMEOUT_RST = 32'd3000;
  localparam logic [PERIOD_BITS-1:0] CHECK_PERIOD_RST = 16'd1000;

  // event opcodes
  localparam logic [OP_BITS-1:0] OP_ACCEPT     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_READY      = 3'd1;
  localparam logic [OP_BITS-1:0] OP_HEARTBEAT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DISCONNECT = 3'd3;
  localparam logic [OP_BITS-1:0] OP_RUN        = 3'd4;
  localparam logic [OP_BITS-1:0] OP_STOP       = 3'd5;
  localparam logic [OP_BITS-1:0] OP_TICK       = 3'd6;

  // phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_READY     = 2'd1;
  localparam logic [1:0] ERR_HEARTBEAT = 2'd2;

  // classified event, one flag per kind; all clear means no-op
  typedef struct packed {
    logic accept;
    logic ready;
    logic heartbeat;
    logic disconnect;
    logic run;
    logic stop;
    logic tick;
    logic id_invalid;
  } cmd_flags_t;

  // per-event result status
  typedef struct packed {
    logic       op_ok;
    logic [1:0] error_code;
    logic       broker_register;
    logic       broker_disconnect;
    logic       send_stopping;
    logic       terminal_fire;
    logic [1:0] phase_now;
    logic       fatal_flag;
    logic       can_admit;
  } res_flags_t;

endpackage
`default_nettype wire

// ===== hdl/hls_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hls_front
// Takes input beats and classifies each event for the command queue.
// ----------------------------------------------------------------------------
module hls_front #(
  parameter int CLIENT_ID_BITS = hls_pkg::CLIENT_ID_BITS_DEF
) (
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [hls_pkg::OP_BITS-1:0]   op,
  input  wire logic [CLIENT_ID_BITS-1:0]     client_id,
  input  wire logic [CLIENT_ID_BITS-1:0]     invalid_id,
  input  wire logic                          q_ready,
  output logic                               push,
  output hls_pkg::cmd_flags_t                flags,
  output logic [CLIENT_ID_BITS-1:0]          cid
);
  import hls_pkg::*;

  // beat moves straight into the queue when it has room
  assign s_tready = q_ready;
  assign push     = s_tvalid & q_ready;
  assign cid      = client_id;

  // opcode decode
  always_comb begin
    flags = '0;
    flags.id_invalid = (client_id == invalid_id);
    case (op)
      OP_ACCEPT:     flags.accept     = 1'b1;
      OP_READY:      flags.ready      = 1'b1;
      OP_HEARTBEAT:  flags.heartbeat  = 1'b1;
      OP_DISCONNECT: flags.disconnect = 1'b1;
      OP_RUN:        flags.run        = 1'b1;
      OP_STOP:       flags.stop       = 1'b1;
      OP_TICK:       flags.tick       = 1'b1;
      default:       flags.id_invalid = flags.id_invalid;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/hls_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hls_queue
// Short command queue between the classify front and the execute back.
// ----------------------------------------------------------------------------
module hls_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   push_ready,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      pop_data
);
  import hls_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hls_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hls_exec
// Lease state machine: applies one queued event per cycle while the result
// register is free or draining, and registers its result beat.
// ----------------------------------------------------------------------------
module hls_exec #(
  parameter int CLIENT_ID_BITS = hls_pkg::CLIENT_ID_BITS_DEF,
  parameter int TIME_BITS      = hls_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // queue side
  input  wire logic                               q_valid,
  input  wire hls_pkg::cmd_flags_t                q_flags,
  input  wire logic [CLIENT_ID_BITS-1:0]          q_cid,
  output logic                                    q_pop,
  // configuration
  input  wire logic [CLIENT_ID_BITS-1:0]          invalid_id,
  input  wire logic [TIME_BITS-1:0]               startup_grace,
  input  wire logic [TIME_BITS-1:0]               lease_timeout,
  input  wire logic [hls_pkg::PERIOD_BITS-1:0]    check_period,
  input  wire logic                               admission_enable,
  // result side
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output hls_pkg::res_flags_t                     res_flags,
  output logic [CLIENT_ID_BITS-1:0]               res_target,
  output logic [CLIENT_ID_BITS-1:0]               res_host,
  output logic                                    fatal_taken
);
  import hls_pkg::*;

  // lease state
  logic [1:0]                phase;
  logic [CLIENT_ID_BITS-1:0] host;
  logic                      ever_accepted;
  logic                      broker_claimed;
  logic                      lease_active;
  logic [TIME_BITS-1:0]      lease_left;
  logic [PERIOD_BITS-1:0]    period_count;
  logic                      fatal_claimed;

  logic [1:0]                phase_next;
  logic [CLIENT_ID_BITS-1:0] host_next;
  logic                      ever_accepted_next;
  logic                      broker_claimed_next;
  logic                      lease_active_next;
  logic [TIME_BITS-1:0]      lease_left_next;
  logic [PERIOD_BITS-1:0]    period_count_next;
  logic                      fatal_claimed_next;
  logic                      fatal_taken_next;

  res_flags_t                flags_next;
  logic [CLIENT_ID_BITS-1:0] target_next;
  logic [PERIOD_BITS-1:0]    tick_count;
  logic                      do_check;

  // take an event whenever the result register is free or draining
  assign q_pop = q_valid & (~res_valid | res_ready);

  // event update
  always_comb begin
    phase_next          = phase;
    host_next           = host;
    ever_accepted_next  = ever_accepted;
    broker_claimed_next = broker_claimed;
    lease_active_next   = lease_active;
    lease_left_next     = lease_left;
    period_count_next   = period_count;
    fatal_claimed_next  = fatal_claimed;
    fatal_taken_next    = fatal_taken;
    flags_next          = '0;
    target_next         = '0;
    do_check            = 1'b0;
    tick_count          = period_count + PERIOD_BITS'(1);

    if (q_flags.accept) begin
      if (admission_enable && phase == PH_START && !ever_accepted &&
          !fatal_claimed && !q_flags.id_invalid) begin
        host_next          = q_cid;
        ever_accepted_next = 1'b1;
        lease_active_next  = 1'b1;
        lease_left_next    = startup_grace;
        flags_next.op_ok   = 1'b1;
        do_check           = 1'b1;
      end
    end else if (q_flags.ready) begin
      if (host == q_cid && !broker_claimed) begin
        broker_claimed_next        = 1'b1;
        flags_next.broker_register = 1'b1;
        target_next                = q_cid;
      end else begin
        flags_next.error_code = ERR_READY;
      end
    end else if (q_flags.heartbeat) begin
      if (host != q_cid) begin
        flags_next.error_code = ERR_HEARTBEAT;
      end else if (lease_active) begin
        lease_left_next = lease_timeout;
      end
    end else if (q_flags.disconnect) begin
      if (host == q_cid) begin
        host_next         = invalid_id;
        lease_active_next = 1'b0;
        if (broker_claimed) begin
          flags_next.broker_disconnect = 1'b1;
          target_next                  = q_cid;
        end
        if (phase != PH_STOP && !fatal_claimed) begin
          fatal_claimed_next = 1'b1;
          do_check           = 1'b1;
        end
      end
    end else if (q_flags.run) begin
      if (phase == PH_START && !fatal_claimed && host != invalid_id) begin
        phase_next       = PH_RUN;
        flags_next.op_ok = 1'b1;
      end
    end else if (q_flags.stop) begin
      if (phase != PH_STOP && !fatal_claimed) begin
        phase_next        = PH_STOP;
        lease_active_next = 1'b0;
        if (host != invalid_id) begin
          flags_next.send_stopping = 1'b1;
          target_next              = host;
        end
      end
    end else if (q_flags.tick) begin
      if (lease_active && lease_left != '0) begin
        lease_left_next = lease_left - TIME_BITS'(1);
      end
      if (tick_count >= check_period || tick_count == '0) begin
        do_check = 1'b1;
      end else begin
        period_count_next = tick_count;
      end
    end

    // lease check: expiry drops the host, fatal report goes out once
    if (do_check) begin
      period_count_next = '0;
      if (lease_active_next && lease_left_next == '0) begin
        host_next         = invalid_id;
        lease_active_next = 1'b0;
        if (phase_next != PH_STOP) begin
          fatal_claimed_next = 1'b1;
        end
      end
      if (fatal_claimed_next && !fatal_taken) begin
        fatal_taken_next         = 1'b1;
        flags_next.terminal_fire = 1'b1;
      end
    end

    flags_next.phase_now  = phase_next;
    flags_next.fatal_flag = fatal_claimed_next;
    flags_next.can_admit  = (phase_next == PH_RUN) && !fatal_claimed_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      host           <= CLIENT_ID_BITS'(INVALID_ID_RST);
      ever_accepted  <= 1'b0;
      broker_claimed <= 1'b0;
      lease_active   <= 1'b0;
      lease_left     <= '0;
      period_count   <= '0;
      fatal_claimed  <= 1'b0;
      fatal_taken    <= 1'b0;
    end else if (q_pop) begin
      phase          <= phase_next;
      host           <= host_next;
      ever_accepted  <= ever_accepted_next;
      broker_claimed <= broker_claimed_next;
      lease_active   <= lease_active_next;
      lease_left     <= lease_left_next;
      period_count   <= period_count_next;
      fatal_claimed  <= fatal_claimed_next;
      fatal_taken    <= fatal_taken_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_flags  <= flags_next;
      res_target <= target_next;
      res_host   <= host_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/host_lease_supervisor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// host_lease_supervisor_top
// Lease supervisor for one remote host: classify front, command queue,
// execute back and configuration registers.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock while the queue has room and
// returns exactly one result beat per event, in order. An event is
// classified on entry, waits in a two-entry queue and is applied by the
// execute stage at one event per cycle while the result register is free
// or draining. The event is registered in the queue and its result in an
// output register, so input beats keep flowing into the queue while a
// result waits, until its two entries are full. The op code travels on
// s_tuser and the client id on s_tdata. Configuration writes land at once
// and must only be issued while no event is in flight.
// ----------------------------------------------------------------------------
module host_lease_supervisor_top #(
  parameter int CLIENT_ID_BITS = hls_pkg::CLIENT_ID_BITS_DEF,
  parameter int TIME_BITS      = hls_pkg::TIME_BITS_DEF,
  localparam int IN_W  = ((CLIENT_ID_BITS + 7) / 8) * 8,
  localparam int RES_W = 11 + 2 * CLIENT_ID_BITS,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8,
  localparam int CFG_W0 = (CLIENT_ID_BITS > TIME_BITS) ? CLIENT_ID_BITS : TIME_BITS,
  localparam int CFG_W = (CFG_W0 > hls_pkg::PERIOD_BITS) ? CFG_W0 : hls_pkg::PERIOD_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // event stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [IN_W-1:0]                   s_tdata,  // client_id
  input  wire logic [hls_pkg::OP_BITS-1:0]       s_tuser,  // op
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // op_ok, error_code, broker_register, broker_disconnect, send_stopping,
  // target_client, terminal_fire, phase_now, fatal_flag, can_admit,
  // current_host, zero fill
  output logic [OUT_W-1:0]                       m_tdata,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [hls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_wdata
);
  import hls_pkg::*;

  localparam int Q_W = $bits(cmd_flags_t) + CLIENT_ID_BITS;

  // configuration registers
  logic [CLIENT_ID_BITS-1:0] invalid_id;
  logic [TIME_BITS-1:0]      startup_grace;
  logic [TIME_BITS-1:0]      lease_timeout;
  logic [PERIOD_BITS-1:0]    check_period;
  logic                      admission_enable;

  logic                      q_ready;
  logic                      push;
  cmd_flags_t                front_flags;
  logic [CLIENT_ID_BITS-1:0] front_cid;
  logic                      q_valid;
  logic                      q_pop;
  logic [Q_W-1:0]            q_data;
  res_flags_t                res_flags;
  logic [CLIENT_ID_BITS-1:0] res_target;
  logic [CLIENT_ID_BITS-1:0] res_host;
  logic                      fatal_taken;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_id       <= CLIENT_ID_BITS'(INVALID_ID_RST);
      startup_grace    <= TIME_BITS'(STARTUP_GRACE_RST);
      lease_timeout    <= TIME_BITS'(LEASE_TIMEOUT_RST);
      check_period     <= CHECK_PERIOD_RST;
      admission_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVALID_ID:    invalid_id       <= cfg_wdata[CLIENT_ID_BITS-1:0];
        REG_STARTUP_GRACE: startup_grace    <= cfg_wdata[TIME_BITS-1:0];
        REG_LEASE_TIMEOUT: lease_timeout    <= cfg_wdata[TIME_BITS-1:0];
        REG_CHECK_PERIOD:  check_period     <= cfg_wdata[PERIOD_BITS-1:0];
        REG_ADMISSION:     admission_enable <= cfg_wdata[0];
        default:           admission_enable <= admission_enable;
      endcase
    end
  end

  // classify front
  hls_front #(
    .CLIENT_ID_BITS (CLIENT_ID_BITS)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .op         (s_tuser),
    .client_id  (s_tdata[CLIENT_ID_BITS-1:0]),
    .invalid_id (invalid_id),
    .q_ready    (q_ready),
    .push       (push),
    .flags      (front_flags),
    .cid        (front_cid)
  );

  // command queue
  hls_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({front_cid, front_flags}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  // execute back
  hls_exec #(
    .CLIENT_ID_BITS (CLIENT_ID_BITS),
    .TIME_BITS      (TIME_BITS)
  ) u_exec (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_flags          (cmd_flags_t'(q_data[$bits(cmd_flags_t)-1:0])),
    .q_cid            (q_data[Q_W-1:$bits(cmd_flags_t)]),
    .q_pop            (q_pop),
    .invalid_id       (invalid_id),
    .startup_grace    (startup_grace),
    .lease_timeout    (lease_timeout),
    .check_period     (check_period),
    .admission_enable (admission_enable),
    .res_valid        (m_tvalid),
    .res_ready        (m_tready),
    .res_flags        (res_flags),
    .res_target       (res_target),
    .res_host         (res_host),
    .fatal_taken      (fatal_taken)
  );

  // result beat packing, lowest field first
  assign m_tdata = {
    {(OUT_W - RES_W){1'b0}},
    res_host,
    res_flags.can_admit,
    res_flags.fatal_flag,
    res_flags.phase_now,
    res_flags.terminal_fire,
    res_target,
    res_flags.send_stopping,
    res_flags.broker_disconnect,
    res_flags.broker_register,
    res_flags.error_code,
    res_flags.op_ok
  };

`ifndef NO_ASSERTIONS
  // a taken event is always held somewhere on the next cycle
  a_event_held: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (q_valid || m_tvalid))
    else $error("accepted event vanished");

  // a fatal report in the result register means it was marked as delivered
  a_fire_marked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_flags.terminal_fire) |-> fatal_taken)
    else $error("fatal report without delivered mark");

  // the delivered mark never clears
  a_fire_sticky: assert property (@(posedge clk) disable iff (rst)
    fatal_taken |=> fatal_taken)
    else $error("fatal delivered mark cleared");

  // a fatal report is never shown without the fatal claim
  a_fire_claim: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_flags.terminal_fire) |-> res_flags.fatal_flag)
    else $error("fatal report without fatal claim");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks host_lease_supervisor_top beat by beat against a cycle-free model
// of the lease rules. A short table of directed events and register writes
// comes first. Random traffic follows in a live session, and one of three
// ways of ending the session closes the run. Both stream sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import hls_pkg::*;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 48;
  localparam int CFG_W       = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SEGMENTS    = 4;
  localparam int SEGMENT_LEN = 400;
  localparam int NOISE_LEN   = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 700;

  // op code the block treats as a no-op
  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
  // the one host this run admits
  localparam logic [15:0] HOST_ID = 16'hFFFF;

  // one result beat, fields in stream order
  typedef struct packed {
    logic        op_ok;
    logic [1:0]  error_code;
    logic        broker_register;
    logic        broker_disconnect;
    logic        send_stopping;
    logic [15:0] target_client;
    logic        terminal_fire;
    logic [1:0]  phase_now;
    logic        fatal_flag;
    logic        can_admit;
    logic [15:0] current_host;
  } lease_result_t;

  typedef enum bit {ROW_EVENT, ROW_CFG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [OP_BITS-1:0]        op;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [31:0]               value;
    bit                        typed;
    lease_result_t             res;
  } plan_row_t;

  typedef enum int {END_STOP, END_EXPIRY, END_HOST_LOST} session_end_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;   // client_id
  logic [OP_BITS-1:0]        s_tuser = '0;   // op
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // op_ok, error_code, broker_register, broker_disconnect, send_stopping,
  // target_client, terminal_fire, phase_now, fatal_flag, can_admit,
  // current_host, zero fill
  logic [OUT_W-1:0]          m_tdata;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  // model registers
  logic [15:0] cf_invalid = INVALID_ID_RST[15:0];
  logic [19:0] cf_grace   = STARTUP_GRACE_RST[19:0];
  logic [19:0] cf_timeout = LEASE_TIMEOUT_RST[19:0];
  logic [15:0] cf_period  = CHECK_PERIOD_RST;
  bit          cf_admit   = 1'b0;

  // model session state
  logic [1:0]  ls_phase      = PH_START;
  logic [15:0] ls_host       = INVALID_ID_RST[15:0];
  bit          ls_accepted   = 1'b0;
  bit          ls_registered = 1'b0;
  bit          ls_lease_on   = 1'b0;
  logic [19:0] ls_lease_left = '0;
  logic [15:0] ls_period_cnt = '0;
  bit          ls_fatal      = 1'b0;
  bit          ls_fatal_sent = 1'b0;

  lease_result_t pending_results[$];
  plan_row_t     plan[$];
  lease_result_t blank_res = '0;

  int  failures     = 0;
  int  events_sent  = 0;
  int  results_seen = 0;
  int  fires_seen   = 0;
  int  errors_seen  = 0;
  int  cfg_writes   = 0;
  int  cycle_count  = 0;
  bit  calm         = 1'b0;
  bit  hold_done    = 1'b0;

  host_lease_supervisor_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lease check: expiry drops the host, fatal report goes out once
  function automatic bit lease_check();
    ls_period_cnt = '0;
    if (ls_lease_on && ls_lease_left == '0) begin
      ls_host     = cf_invalid;
      ls_lease_on = 1'b0;
      if (ls_phase != PH_STOP && !ls_fatal) ls_fatal = 1'b1;
    end
    if (ls_fatal && !ls_fatal_sent) begin
      ls_fatal_sent = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one event to the model and returns the result beat it causes
  function automatic lease_result_t lease_step(input logic [OP_BITS-1:0] op,
                                               input logic [15:0] cid);
    lease_result_t r;
    bit            lost;
    logic [15:0]   period_next;
    r = '0;
    case (op)
      OP_ACCEPT: begin
        if (cf_admit && ls_phase == PH_START && !ls_accepted && !ls_fatal &&
            cid != cf_invalid) begin
          ls_host       = cid;
          ls_accepted   = 1'b1;
          ls_lease_on   = 1'b1;
          ls_lease_left = cf_grace;
          r.op_ok         = 1'b1;
          r.terminal_fire = lease_check();
        end
      end
      OP_READY: begin
        if (ls_host == cid && !ls_registered) begin
          ls_registered     = 1'b1;
          r.broker_register = 1'b1;
          r.target_client   = cid;
        end else begin
          r.error_code = ERR_READY;
        end
      end
      OP_HEARTBEAT: begin
        if (ls_host != cid) r.error_code = ERR_HEARTBEAT;
        else if (ls_lease_on) ls_lease_left = cf_timeout;
      end
      OP_DISCONNECT: begin
        if (ls_host == cid) begin
          lost        = (ls_phase != PH_STOP);
          ls_host     = cf_invalid;
          ls_lease_on = 1'b0;
          if (ls_registered) begin
            r.broker_disconnect = 1'b1;
            r.target_client     = cid;
          end
          if (lost && !ls_fatal) begin
            ls_fatal        = 1'b1;
            r.terminal_fire = lease_check();
          end
        end
      end
      OP_RUN: begin
        if (ls_phase == PH_START && !ls_fatal && ls_host != cf_invalid) begin
          ls_phase = PH_RUN;
          r.op_ok  = 1'b1;
        end
      end
      OP_STOP: begin
        if (ls_phase != PH_STOP && !ls_fatal) begin
          ls_phase    = PH_STOP;
          ls_lease_on = 1'b0;
          if (ls_host != cf_invalid) begin
            r.send_stopping = 1'b1;
            r.target_client = ls_host;
          end
        end
      end
      OP_TICK: begin
        if (ls_lease_on && ls_lease_left != '0) ls_lease_left = ls_lease_left - 20'd1;
        // a period of zero behaves as one
        period_next = ls_period_cnt + 16'd1;
        if (period_next >= cf_period || period_next == '0) r.terminal_fire = lease_check();
        else ls_period_cnt = period_next;
      end
      default: ;
    endcase
    r.phase_now    = ls_phase;
    r.fatal_flag   = ls_fatal;
    r.can_admit    = (ls_phase == PH_RUN) && !ls_fatal;
    r.current_host = ls_host;
    return r;
  endfunction

  function automatic void add_event(input logic [OP_BITS-1:0] op, input logic [15:0] cid,
                                    input bit typed, input lease_result_t res);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_EVENT;
    row.op    = op;
    row.value = {16'd0, cid};
    row.typed = typed;
    row.res   = res;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [31:0] value);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG_WRITE;
    row.idx   = idx;
    row.value = value;
    plan.push_back(row);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // offer one event beat and record what it should produce
  task automatic send_event(input logic [OP_BITS-1:0] op, input logic [15:0] cid,
                            input bit typed, input lease_result_t typed_res);
    int            gap;
    lease_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= cid;
    do @(posedge clk); while (!s_tready);
    pred = lease_step(op, cid);
    pending_results.push_back(typed ? typed_res : pred);
    events_sent++;
  endtask

  // stop offering and let every result drain out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INVALID_ID:    cf_invalid = value[15:0];
      REG_STARTUP_GRACE: cf_grace   = value[19:0];
      REG_LEASE_TIMEOUT: cf_timeout = value[19:0];
      REG_CHECK_PERIOD:  cf_period  = value[15:0];
      REG_ADMISSION:     cf_admit   = value[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // result side: random stalls, one long hold-off once traffic is flowing
  initial begin : result_sink
    int stall;
    stall = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    lease_result_t got;
    lease_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.op_ok             = m_tdata[0];
      got.error_code        = m_tdata[2:1];
      got.broker_register   = m_tdata[3];
      got.broker_disconnect = m_tdata[4];
      got.send_stopping     = m_tdata[5];
      got.target_client     = m_tdata[21:6];
      got.terminal_fire     = m_tdata[22];
      got.phase_now         = m_tdata[24:23];
      got.fatal_flag        = m_tdata[25];
      got.can_admit         = m_tdata[26];
      got.current_host      = m_tdata[42:27];
      results_seen++;
      if (got.terminal_fire) fires_seen++;
      if (got.error_code != ERR_NONE) errors_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no event waiting for it");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("op_ok", want.op_ok, got.op_ok);
        check_field("error_code", want.error_code, got.error_code);
        check_field("broker_register", want.broker_register, got.broker_register);
        check_field("broker_disconnect", want.broker_disconnect, got.broker_disconnect);
        check_field("send_stopping", want.send_stopping, got.send_stopping);
        check_field("target_client", want.target_client, got.target_client);
        check_field("terminal_fire", want.terminal_fire, got.terminal_fire);
        check_field("phase_now", want.phase_now, got.phase_now);
        check_field("fatal_flag", want.fatal_flag, got.fatal_flag);
        check_field("can_admit", want.can_admit, got.can_admit);
        check_field("current_host", want.current_host, got.current_host);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    lease_result_t idle_res;
    lease_result_t ready_err;
    lease_result_t beat_err;
    session_end_t  ending;
    int            r;
    logic [OP_BITS-1:0] op;
    logic [15:0]   cid;

    // after reset: starting, no host, nothing raised
    idle_res              = '0;
    idle_res.phase_now    = PH_START;
    idle_res.current_host = INVALID_ID_RST[15:0];
    ready_err             = idle_res;
    ready_err.error_code  = ERR_READY;
    beat_err              = idle_res;
    beat_err.error_code   = ERR_HEARTBEAT;

    // reset values, admission off
    add_event(OP_TICK, 16'h0000, 1'b1, idle_res);
    add_event(OP_ACCEPT, 16'h1234, 1'b1, idle_res);
    add_event(OP_UNUSED, 16'hFFFF, 1'b1, idle_res);
    add_event(OP_HEARTBEAT, 16'h0000, 1'b1, beat_err);
    add_event(OP_READY, 16'h5555, 1'b1, ready_err);
    add_event(OP_HEARTBEAT, 16'hFFFF, 1'b1, idle_res);
    add_event(OP_RUN, 16'h0000, 1'b1, idle_res);
    add_event(OP_DISCONNECT, 16'hAAAA, 1'b1, idle_res);
    // open admission, longest leases and period, no-host id at zero
    add_cfg(REG_ADMISSION, 32'd1);
    add_cfg(REG_STARTUP_GRACE, 32'hFFFFF);
    add_cfg(REG_LEASE_TIMEOUT, 32'hFFFFF);
    add_cfg(REG_CHECK_PERIOD, 32'hFFFF);
    add_cfg(REG_INVALID_ID, 32'd0);
    // accept rules, registration, heartbeat, tick, run, disconnect
    add_event(OP_ACCEPT, 16'h0000, 1'b0, blank_res);
    add_event(OP_ACCEPT, HOST_ID, 1'b0, blank_res);
    add_event(OP_ACCEPT, 16'h0001, 1'b0, blank_res);
    add_event(OP_READY, 16'h0002, 1'b0, blank_res);
    add_event(OP_HEARTBEAT, 16'h0003, 1'b0, blank_res);
    add_event(OP_READY, HOST_ID, 1'b0, blank_res);
    add_event(OP_READY, HOST_ID, 1'b0, blank_res);
    add_event(OP_HEARTBEAT, HOST_ID, 1'b0, blank_res);
    add_event(OP_TICK, 16'h0000, 1'b0, blank_res);
    add_event(OP_RUN, 16'h0000, 1'b0, blank_res);
    add_event(OP_RUN, 16'h0000, 1'b0, blank_res);
    add_event(OP_DISCONNECT, 16'h0000, 1'b0, blank_res);
    // zero period checks on every tick
    add_cfg(REG_CHECK_PERIOD, 32'd0);
    add_event(OP_TICK, 16'h0000, 1'b0, blank_res);
    add_event(OP_TICK, 16'h0000, 1'b0, blank_res);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG_WRITE) begin
        wait_idle();
        cfg_write(plan[i].idx, plan[i].value);
      end else begin
        send_event(plan[i].op, plan[i].value[15:0], plan[i].typed, plan[i].res);
      end
    end

    // random traffic in a live session, new settings per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      cfg_write(REG_LEASE_TIMEOUT, $urandom_range(24, 64));
      cfg_write(REG_CHECK_PERIOD, (seg == SEGMENTS - 1) ? 32'hFFFF : $urandom_range(1, 12));
      cfg_write(REG_INVALID_ID, $urandom_range(0, 16'hFFFE));
      cfg_write(REG_STARTUP_GRACE, $urandom);
      cfg_write(REG_ADMISSION, $urandom_range(0, 1));
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        r   = $urandom_range(0, 99);
        cid = 16'($urandom_range(0, 16'hFFFF));
        // mostly ticks and host heartbeats, some stray messages
        if (r < 45) begin
          op = OP_TICK;
        end else if (r < 70) begin
          op  = OP_HEARTBEAT;
          cid = HOST_ID;
        end else if (r < 76) begin
          op = OP_HEARTBEAT;
        end else if (r < 81) begin
          op = OP_READY;
          if (r[0]) cid = HOST_ID;
        end else if (r < 85) begin
          op = OP_ACCEPT;
        end else if (r < 89) begin
          op = OP_RUN;
        end else if (r < 92) begin
          op = OP_UNUSED;
        end else begin
          op  = OP_DISCONNECT;
          cid = 16'($urandom_range(0, 16'hFFFE));
        end
        send_event(op, cid, 1'b0, blank_res);
      end
    end

    // close the session one of three ways
    calm   = 1'b0;
    ending = session_end_t'($urandom_range(0, 2));
    case (ending)
      END_STOP: begin
        send_event(OP_STOP, 16'($urandom_range(0, 16'hFFFF)), 1'b0, blank_res);
      end
      END_EXPIRY: begin
        // zero lease runs out at the next check
        wait_idle();
        cfg_write(REG_LEASE_TIMEOUT, 32'd0);
        cfg_write(REG_CHECK_PERIOD, $urandom_range(1, 12));
        send_event(OP_HEARTBEAT, HOST_ID, 1'b0, blank_res);
        repeat (14) send_event(OP_TICK, 16'($urandom_range(0, 16'hFFFF)), 1'b0, blank_res);
      end
      default: begin
        send_event(OP_DISCONNECT, HOST_ID, 1'b0, blank_res);
      end
    endcase

    // anything goes once the session has ended
    for (int k = 0; k < NOISE_LEN; k++) begin
      r = $urandom_range(0, 3);
      if (r < 2) cid = HOST_ID;
      else if (r == 2) cid = cf_invalid;
      else cid = 16'($urandom_range(0, 16'hFFFF));
      op = OP_BITS'($urandom_range(0, 7));
      send_event(op, cid, 1'b0, blank_res);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("testbench: %0d events, %0d result beats, %0d register writes, ended by %s",
             events_sent, results_seen, cfg_writes, ending.name());
    $display("testbench: %0d host-lost reports and %0d rejected messages seen",
             fires_seen, errors_seen);
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
